// ----- rtl/fcpf_pkg.sv -----
// Shared types, constants and the mod-255 adder of the packet framer.
package fcpf_pkg;

  localparam int unsigned LEN_W       = 10;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned JOB_DEPTH   = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned MAX_PAYLOAD = 512;

  localparam logic [15:0]       TOKEN_WORD    = 16'hB5AD;
  localparam logic [BYTE_W:0]   FLETCHER_MOD  = 9'd255;
  localparam logic              CMD_START     = 1'b0;
  localparam logic              CMD_DATA      = 1'b1;
  localparam logic [IDX_W-1:0]  IDX_HEADER_END = 3'd7;
  localparam logic [IDX_W-1:0]  IDX_SUM_END    = 3'd2;
  localparam logic [IDX_W-1:0]  IDX_FIRST      = 3'd0;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] sync_number;
    logic [3:0]        protocol_id;
    logic [3:0]        packet_type;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] hdr_sum_low;
    logic [BYTE_W-1:0] hdr_sum_high;
  } in_item_t;

  typedef struct packed {
    logic [JOB_DEPTH-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
    logic                             last_flag;
    logic                             err;
  } job_t;

  function automatic logic [BYTE_W-1:0] add_mod255(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= FLETCHER_MOD) begin
      s = s - FLETCHER_MOD;
    end
    return s[BYTE_W-1:0];
  endfunction

endpackage

// ----- rtl/fcpf_in_stage.sv -----
// Input register with the header checksum over sync, type and length bytes.
module fcpf_in_stage import fcpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [BYTE_W-1:0] sync_number_i,
  input  logic [3:0]        protocol_id_i,
  input  logic [3:0]        packet_type_i,
  input  logic [LEN_W-1:0]  payload_length_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              take_i,
  output logic              item_valid_o,
  output in_item_t          item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;
  logic     accept;

  logic [BYTE_W-1:0] hdr3, hdr4, hdr5;
  logic [BYTE_W-1:0] lo2, hi2, lo3, hi3, lo4, hi4, lo5, hi5;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hdr3 = {protocol_id_i, packet_type_i};
    hdr4 = payload_length_i[BYTE_W-1:0];
    hdr5 = {{(2*BYTE_W-LEN_W){1'b0}}, payload_length_i[LEN_W-1:BYTE_W]};
    lo2  = add_mod255('0, sync_number_i);
    hi2  = lo2;
    lo3  = add_mod255(lo2, hdr3);
    hi3  = add_mod255(hi2, lo3);
    lo4  = add_mod255(lo3, hdr4);
    hi4  = add_mod255(hi3, lo4);
    lo5  = add_mod255(lo4, hdr5);
    hi5  = add_mod255(hi4, lo5);

    item_d.cmd            = cmd_i;
    item_d.sync_number    = sync_number_i;
    item_d.protocol_id    = protocol_id_i;
    item_d.packet_type    = packet_type_i;
    item_d.payload_length = payload_length_i;
    item_d.data_byte      = data_byte_i;
    item_d.hdr_sum_low    = lo5;
    item_d.hdr_sum_high   = hi5;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/fcpf_build.sv -----
// Packet state and construction of the result beats for one item.
module fcpf_build import fcpf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  logic     load_i,
  output job_t     job_o
);

  logic [BYTE_W-1:0] sum_low_q, sum_low_d;
  logic [BYTE_W-1:0] sum_high_q, sum_high_d;
  logic [LEN_W-1:0]  bytes_left_q, bytes_left_d;
  logic              open_q, open_d;

  logic [BYTE_W-1:0] h_lo6, h_hi6, h_lo7, h_hi7;
  logic [BYTE_W-1:0] p_lo, p_hi;
  logic [LEN_W-1:0]  left_dec;
  logic [BYTE_W-1:0] hdr5;

  always_comb begin
    h_lo6    = add_mod255(item_i.hdr_sum_low, item_i.hdr_sum_low);
    h_hi6    = add_mod255(item_i.hdr_sum_high, h_lo6);
    h_lo7    = add_mod255(h_lo6, item_i.hdr_sum_high);
    h_hi7    = add_mod255(h_hi6, h_lo7);
    p_lo     = add_mod255(sum_low_q, item_i.data_byte);
    p_hi     = add_mod255(sum_high_q, p_lo);
    left_dec = bytes_left_q - LEN_W'(1);
    hdr5     = {{(2*BYTE_W-LEN_W){1'b0}}, item_i.payload_length[LEN_W-1:BYTE_W]};

    sum_low_d     = sum_low_q;
    sum_high_d    = sum_high_q;
    bytes_left_d  = bytes_left_q;
    open_d        = open_q;
    job_o.bytes     = '0;
    job_o.last_idx  = IDX_FIRST;
    job_o.last_flag = 1'b1;
    job_o.err       = 1'b1;

    case (item_i.cmd)
      CMD_START: begin
        if (item_i.payload_length > LEN_W'(MAX_PAYLOAD)) begin
          open_d       = 1'b0;
          bytes_left_d = '0;
        end else begin
          job_o.bytes[0]  = TOKEN_WORD[7:0];
          job_o.bytes[1]  = TOKEN_WORD[15:8];
          job_o.bytes[2]  = item_i.sync_number;
          job_o.bytes[3]  = {item_i.protocol_id, item_i.packet_type};
          job_o.bytes[4]  = item_i.payload_length[BYTE_W-1:0];
          job_o.bytes[5]  = hdr5;
          job_o.bytes[6]  = item_i.hdr_sum_low;
          job_o.bytes[7]  = item_i.hdr_sum_high;
          job_o.last_idx  = IDX_HEADER_END;
          job_o.last_flag = (item_i.payload_length == '0);
          job_o.err       = 1'b0;
          sum_low_d       = h_lo7;
          sum_high_d      = h_hi7;
          bytes_left_d    = item_i.payload_length;
          open_d          = (item_i.payload_length != '0);
        end
      end
      CMD_DATA: begin
        if (open_q && (bytes_left_q != '0)) begin
          sum_low_d      = p_lo;
          sum_high_d     = p_hi;
          bytes_left_d   = left_dec;
          job_o.bytes[0] = item_i.data_byte;
          job_o.err      = 1'b0;
          if (left_dec == '0) begin
            open_d          = 1'b0;
            job_o.bytes[1]  = p_lo;
            job_o.bytes[2]  = p_hi;
            job_o.last_idx  = IDX_SUM_END;
            job_o.last_flag = 1'b1;
          end else begin
            job_o.last_flag = 1'b0;
          end
        end
      end
      default: begin
        job_o.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_low_q    <= '0;
      sum_high_q   <= '0;
      bytes_left_q <= '0;
      open_q       <= 1'b0;
    end else if (load_i) begin
      sum_low_q    <= sum_low_d;
      sum_high_q   <= sum_high_d;
      bytes_left_q <= bytes_left_d;
      open_q       <= open_d;
    end
  end

endmodule

// ----- rtl/fcpf_emit.sv -----
// Result register that sends the beats of one job in order.
module fcpf_emit import fcpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              job_i,
  input  logic              load_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_o,
  output logic              error_o
);

  logic             valid_q, valid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  job_t             job_q;
  logic             at_end;

  assign at_end = (idx_q == job_q.last_idx);
  assign free_o = !valid_q || (at_end && out_ready_i);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = IDX_FIRST;
    end else if (valid_q && out_ready_i) begin
      if (at_end) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = job_q.bytes[idx_q];
  assign last_o      = job_q.last_flag && at_end;
  assign error_o     = job_q.err;

endmodule

// ----- rtl/fletcher_checksum_packet_framer_core.sv -----
// Fletcher-16 packet framer: input register, beat builder and result register.
// An accepted input beat is registered in the input register, then loaded into the result register once it is free.
// Throughput: the output port sets the pace at one beat per cycle; a start beat
// yields 8 result beats, a payload beat 1, the final
// payload beat 3, an error 1. One input beat waits while results drain.
// Reset (rst_ni low, asynchronous) clears the running sums and the open packet.
module fletcher_checksum_packet_framer_core import fcpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [BYTE_W-1:0] sync_number_i,
  input  logic [3:0]        protocol_id_i,
  input  logic [3:0]        packet_type_i,
  input  logic [LEN_W-1:0]  payload_length_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_o,
  output logic              error_o
);

  in_item_t item;
  logic     item_valid;
  job_t     job;
  logic     emit_free;
  logic     load;

  assign load = item_valid && emit_free;

  fcpf_in_stage u_in_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .sync_number_i    (sync_number_i),
    .protocol_id_i    (protocol_id_i),
    .packet_type_i    (packet_type_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .take_i           (load),
    .item_valid_o     (item_valid),
    .item_o           (item)
  );

  fcpf_build u_build (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .load_i (load),
    .job_o  (job)
  );

  fcpf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .load_i      (load),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

// ----- test/fletcher_checksum_packet_framer_core_tb.sv -----
// Testbench for the Fletcher-16 packet framer core: directed and random command beats, byte-exact check.
`timescale 1ns / 100ps

module fletcher_checksum_packet_framer_core_tb;
  import fcpf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              err;
  } wire_beat_t;

  class frame_scoreboard;
    logic [BYTE_W-1:0] run_lo;
    logic [BYTE_W-1:0] run_hi;
    logic [LEN_W-1:0]  left_cnt;
    logic              open_pkt;
    wire_beat_t        wire_due[$];
    int unsigned       fail_cnt;
    int unsigned       checked_cnt;

    function new();
      run_lo      = '0;
      run_hi      = '0;
      left_cnt    = '0;
      open_pkt    = 1'b0;
      fail_cnt    = 0;
      checked_cnt = 0;
    endfunction

    function void fold(input logic [BYTE_W-1:0] b);
      int unsigned lo;
      int unsigned hi;
      lo     = (int'(run_lo) + int'(b)) % int'(FLETCHER_MOD);
      hi     = (int'(run_hi) + lo) % int'(FLETCHER_MOD);
      run_lo = lo[BYTE_W-1:0];
      run_hi = hi[BYTE_W-1:0];
    endfunction

    function void push(input logic [BYTE_W-1:0] value, input logic last, input logic err);
      wire_beat_t b;
      b.value = value;
      b.last  = last;
      b.err   = err;
      wire_due.push_back(b);
    endfunction

    function void take_command(input logic cmd, input logic [BYTE_W-1:0] sync,
                               input logic [3:0] proto, input logic [3:0] ptype,
                               input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] hdr[8];
      int                i;
      if (cmd == CMD_START) begin
        if (len > MAX_PAYLOAD) begin
          open_pkt = 1'b0;
          left_cnt = '0;
          push('0, 1'b1, 1'b1);
          return;
        end
        hdr[0] = TOKEN_WORD[7:0];
        hdr[1] = TOKEN_WORD[15:8];
        hdr[2] = sync;
        hdr[3] = {proto, ptype};
        hdr[4] = len[7:0];
        hdr[5] = 8'(len >> 8);
        run_lo = '0;
        run_hi = '0;
        for (i = 2; i < 6; i++) fold(hdr[i]);
        hdr[6] = run_lo;
        hdr[7] = run_hi;
        fold(hdr[6]);
        fold(hdr[7]);
        for (i = 0; i < 8; i++) push(hdr[i], (i == 7) && (len == 0), 1'b0);
        left_cnt = len;
        open_pkt = (len != 0);
      end else begin
        if (!open_pkt || left_cnt == 0) begin
          push('0, 1'b1, 1'b1);
          return;
        end
        fold(data);
        left_cnt = left_cnt - 1'b1;
        push(data, 1'b0, 1'b0);
        if (left_cnt == 0) begin
          open_pkt = 1'b0;
          push(run_lo, 1'b0, 1'b0);
          push(run_hi, 1'b1, 1'b0);
        end
      end
    endfunction

    function void check_wire_byte(input logic [BYTE_W-1:0] value, input logic last,
                                  input logic err);
      wire_beat_t e;
      if (wire_due.size() == 0) begin
        $display("%0t: unexpected output beat: out_byte %h last %b error %b",
                 $time, value, last, err);
        fail_cnt++;
        return;
      end
      e = wire_due.pop_front();
      checked_cnt++;
      if (value !== e.value) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.value, value);
        fail_cnt++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, last);
        fail_cnt++;
      end
      if (err !== e.err) begin
        $display("%0t: error expected %b actual %b", $time, e.err, err);
        fail_cnt++;
      end
    endfunction
  endclass

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_ready_o;
  logic              cmd_i            = CMD_START;
  logic [BYTE_W-1:0] sync_number_i    = '0;
  logic [3:0]        protocol_id_i    = '0;
  logic [3:0]        packet_type_i    = '0;
  logic [LEN_W-1:0]  payload_length_i = '0;
  logic [BYTE_W-1:0] data_byte_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i      = 1'b0;
  logic [BYTE_W-1:0] out_byte_o;
  logic              last_o;
  logic              error_o;

  frame_scoreboard board;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     sent_cnt      = 0;
  int unsigned     start_cnt     = 0;
  int unsigned     phase_goal;

  fletcher_checksum_packet_framer_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .sync_number_i    (sync_number_i),
    .protocol_id_i    (protocol_id_i),
    .packet_type_i    (packet_type_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .error_o          (error_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      board.take_command(cmd_i, sync_number_i, protocol_id_i, packet_type_i,
                         payload_length_i, data_byte_i);
      if (cmd_i == CMD_START) start_cnt++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_wire_byte(out_byte_o, last_o, error_o);
    end
  end

  task automatic send_cmd(input logic cmd, input logic [BYTE_W-1:0] sync,
                          input logic [3:0] proto, input logic [3:0] ptype,
                          input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= cmd;
    sync_number_i    <= sync;
    protocol_id_i    <= proto;
    packet_type_i    <= ptype;
    payload_length_i <= len;
    data_byte_i      <= data;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  task automatic start_pkt(input logic [BYTE_W-1:0] sync, input logic [3:0] proto,
                           input logic [3:0] ptype, input logic [LEN_W-1:0] len);
    send_cmd(CMD_START, sync, proto, ptype, len, 8'($urandom));
  endtask

  task automatic data_beat(input logic [BYTE_W-1:0] data);
    send_cmd(CMD_DATA, 8'($urandom), 4'($urandom), 4'($urandom), 10'($urandom), data);
  endtask

  task automatic random_frame();
    int unsigned r;
    int unsigned len;
    int unsigned n_send;
    r = $urandom_range(99);
    if (r < 5) begin
      start_pkt(8'($urandom), 4'($urandom), 4'($urandom),
                10'($urandom_range(MAX_PAYLOAD + 1, 1023)));
    end else if (r < 10) begin
      data_beat(8'($urandom));
    end else begin
      r = $urandom_range(99);
      if (r < 60) len = $urandom_range(0, 6);
      else if (r < 90) len = $urandom_range(7, 24);
      else len = $urandom_range(25, 60);
      n_send = len;
      // drop the tail of some packets so the next start abandons them
      if (len > 1 && $urandom_range(99) < 10) n_send = $urandom_range(0, len - 1);
      start_pkt(8'($urandom), 4'($urandom), 4'($urandom), 10'(len));
      repeat (n_send) data_beat(8'($urandom));
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 55;

    data_beat(8'hFF);
    start_pkt(8'h00, 4'h0, 4'h0, 10'd0);
    start_pkt(8'hFF, 4'hF, 4'hF, 10'd0);
    start_pkt(8'h12, 4'h1, 4'h2, 10'(MAX_PAYLOAD + 1));
    start_pkt(8'hFF, 4'hF, 4'hF, 10'h3FF);
    start_pkt(8'h7E, 4'h9, 4'h6, 10'(MAX_PAYLOAD));
    data_beat(8'h00);
    data_beat(8'hFF);
    data_beat(8'h80);
    start_pkt(8'hA5, 4'h3, 4'hC, 10'd1);
    data_beat(8'h00);
    start_pkt(8'h5A, 4'hC, 4'h3, 10'd2);
    data_beat(8'hFF);
    data_beat(8'hFE);
    data_beat(8'h01);
    start_pkt(8'h33, 4'h7, 4'h8, 10'd3);
    data_beat(8'h55);
    start_pkt(8'hC3, 4'h4, 4'hB, 10'd600);
    data_beat(8'hAA);

    phase_goal = sent_cnt + 44;
    while (sent_cnt < phase_goal) random_frame();

    send_idle_pct = 55;
    recv_idle_pct = 13;
    phase_goal = sent_cnt + 44;
    while (sent_cnt < phase_goal) random_frame();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_goal = sent_cnt + 44;
    while (sent_cnt < phase_goal) random_frame();

    in_valid_i <= 1'b0;
    while (board.wire_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (board.wire_due.size() != 0) begin
      $display("%0t: %0d output beats never arrived", $time, board.wire_due.size());
      board.fail_cnt++;
    end
    $display("Run covered %0d command beats (%0d packet starts) under three stall patterns,",
             sent_cnt, start_cnt);
    $display("with %0d output bytes compared and %0d mismatches.",
             board.checked_cnt, board.fail_cnt);
    if (board.fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout: output beats still pending");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
